@@ sv/aelp_pkg.sv @@
// ----------------------------------------------------------------------------
// aelp_pkg: shared types and constants for the escape sequence line parser
// Parser modes, line-store actions, byte codes and the command record that
// the front end hands to the back end through the command queue.
// ----------------------------------------------------------------------------
package aelp_pkg;

  // Default sizing
  localparam int MAX_PARAMS_DEF     = 8;
  localparam int CSI_BYTE_LIMIT_DEF = 63;
  localparam int TAB_WIDTH_DEF      = 8;
  localparam int MAX_COLUMN_DEF     = 1023;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // Fixed limits
  localparam int          MAX_RESULTS = 8;
  localparam logic [9:0]  COLS_RESET  = 10'd80;
  localparam logic [9:0]  OUT_COL_MAX = 10'd1023;
  localparam logic [15:0] PARAM_MAX   = 16'hFFFF;

  // Byte codes
  localparam logic [7:0] CH_BEL     = 8'h07;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_FIN_LO  = 8'h40;
  localparam logic [7:0] CH_UP_C    = 8'h43;
  localparam logic [7:0] CH_UP_D    = 8'h44;
  localparam logic [7:0] CH_UP_G    = 8'h47;
  localparam logic [7:0] CH_UP_H    = 8'h48;
  localparam logic [7:0] CH_UP_J    = 8'h4A;
  localparam logic [7:0] CH_UP_K    = 8'h4B;
  localparam logic [7:0] CH_UP_P    = 8'h50;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_FIN_HI  = 8'h7E;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_HIGH    = 8'h80;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_CSI    = 3'd2,
    MODE_OSC    = 3'd3,
    MODE_GFX    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ACT_WRITE        = 3'd0,
    ACT_NEWLINE      = 3'd1,
    ACT_ERASE_END    = 3'd2,
    ACT_ERASE_BEFORE = 3'd3,
    ACT_ERASE_LINE   = 3'd4,
    ACT_CLEAR        = 3'd5,
    ACT_PASS         = 3'd6
  } act_t;

  // One queued command; expands to cnt items in the back end
  typedef struct packed {
    act_t       act;
    logic [9:0] col;        // saturated column of the first item
    logic [7:0] chr;        // byte of the items (after the ESC when esc_first)
    logic [3:0] cnt;        // item count, 1..MAX_RESULTS
    logic       esc_first;  // first item carries ESC
    logic       step_col;   // column advances by one per item
  } cmd_t;

endpackage

@@ sv/aelp_queue.sv @@
// ----------------------------------------------------------------------------
// aelp_queue: command queue between parser front end and item back end
// Small register FIFO of command records; head is read combinationally.
// ----------------------------------------------------------------------------
module aelp_queue
  import aelp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == NW'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/aelp_front.sv @@
// ----------------------------------------------------------------------------
// aelp_front: byte parser front end
// Accepts one byte per cycle while the queue is not full, tracks mode, cursor
// and CSI parameters, and pushes at most one command per byte into the queue.
// ----------------------------------------------------------------------------
module aelp_front
  import aelp_pkg::*;
#(
  parameter int MAX_PARAMS     = MAX_PARAMS_DEF,
  parameter int CSI_BYTE_LIMIT = CSI_BYTE_LIMIT_DEF,
  parameter int TAB_WIDTH      = TAB_WIDTH_DEF,
  parameter int MAX_COLUMN     = MAX_COLUMN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       cfg_wr_en,
  input  logic [9:0] cfg_screen_columns,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int CW  = $clog2(MAX_COLUMN + 1);          // cursor width
  localparam int SW  = ((CW > 16) ? CW : 16) + 1;        // move arithmetic
  localparam int WW  = (CW + 1 > 10) ? CW + 1 : 10;      // width compare
  localparam int PIX = $clog2(MAX_PARAMS);
  localparam int PIW = $clog2(MAX_PARAMS + 1);
  localparam int CBW = $clog2(CSI_BYTE_LIMIT + 1);
  localparam int TRW = $clog2(TAB_WIDTH + 1);
  localparam int TS  = CW + 5;                           // reciprocal shift
  localparam int TM  = ((1 << TS) + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam int PW  = CW + TS;

  mode_t            mode_r, mode_nxt;
  logic [CW-1:0]    cur_r, cur_nxt;
  logic [7:0]       prev_r;
  logic [15:0]      params_r [MAX_PARAMS];
  logic [15:0]      params_nxt [MAX_PARAMS];
  logic [PIW-1:0]   pidx_r, pidx_nxt;
  logic [CBW-1:0]   csicnt_r, csicnt_nxt;
  logic [9:0]       cols_r;

  logic             accept;
  logic [7:0]       b;
  logic [SW-1:0]    cur_w;
  logic [SW-1:0]    eff_w;
  logic [WW-1:0]    cols_x;
  logic [9:0]       cur_sat;
  logic [15:0]      p0, p1, step;
  logic [SW-1:0]    fwd_w;
  logic [19:0]      dig_w;
  logic [15:0]      dig_val;
  logic [PW-1:0]    tab_prod;
  logic [CW-1:0]    tab_q;
  logic [TRW-1:0]   tab_rem;
  logic [SW-1:0]    tab_dist, tab_room, tab_sel, tab_end;
  logic [3:0]       tab_cnt;

  function automatic logic [CW-1:0] clamp_col(input logic [15:0] v,
                                              input logic [SW-1:0] effw);
    logic [SW-1:0] vw;
    vw = SW'(v);
    if (vw >= effw) return CW'(effw - SW'(1));
    else return CW'(vw);
  endfunction

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign b        = in_byte_in;
  assign cur_w    = SW'(cur_r);
  assign cur_sat  = (cur_w > SW'(OUT_COL_MAX)) ? OUT_COL_MAX : cur_w[9:0];
  assign p0       = params_r[0];
  assign p1       = params_r[1];
  assign step     = (p0 != '0) ? p0 : 16'd1;
  assign fwd_w    = cur_w + SW'(step);

  // effective width: 0 acts as 1, capped at MAX_COLUMN+1
  always_comb begin
    cols_x = WW'(cols_r);
    if (cols_r == '0) begin
      eff_w = SW'(1);
    end else if (cols_x > WW'(MAX_COLUMN + 1)) begin
      eff_w = SW'(MAX_COLUMN + 1);
    end else begin
      eff_w = SW'(cols_x);
    end
  end

  // tab stop distance: cursor mod TAB_WIDTH through an exact reciprocal
  always_comb begin
    tab_prod = PW'(cur_r) * PW'(TM);
    tab_q    = CW'(tab_prod >> TS);
    tab_rem  = TRW'(cur_r - CW'(tab_q * CW'(TAB_WIDTH)));
    tab_dist = SW'(TAB_WIDTH) - SW'(tab_rem);
    tab_room = (cur_w < eff_w) ? eff_w - cur_w : '0;
    tab_sel  = (tab_room < tab_dist) ? tab_room : tab_dist;
    // cursor pins at MAX_COLUMN on a full-width screen: spaces run to the item limit
    if (tab_room != '0 && eff_w > SW'(MAX_COLUMN) && cur_w + tab_dist > SW'(MAX_COLUMN))
      tab_sel = SW'(MAX_RESULTS);
    if (tab_sel > SW'(MAX_RESULTS)) tab_sel = SW'(MAX_RESULTS);
    tab_cnt  = 4'(tab_sel);
    tab_end  = cur_w + tab_sel;
    if (tab_end > SW'(MAX_COLUMN)) tab_end = SW'(MAX_COLUMN);
  end

  // parameter digit accumulate, saturating
  always_comb begin
    dig_w = 20'd0;
    if (pidx_r < PIW'(MAX_PARAMS)) begin
      dig_w = 20'(params_r[pidx_r[PIX-1:0]]) * 20'd10 + 20'(b - CH_0);
    end
    dig_val = (dig_w > 20'(PARAM_MAX)) ? PARAM_MAX : dig_w[15:0];
  end

  always_comb begin
    mode_nxt   = mode_r;
    cur_nxt    = cur_r;
    params_nxt = params_r;
    pidx_nxt   = pidx_r;
    csicnt_nxt = csicnt_r;
    q_push     = 1'b0;
    q_cmd      = '{act: ACT_WRITE, col: cur_sat, chr: 8'd0, cnt: 4'd1,
                   esc_first: 1'b0, step_col: 1'b0};
    if (accept) begin
      unique case (mode_r)
        MODE_NORMAL: begin
          if (b == CH_ESC) begin
            mode_nxt = MODE_ESC;
          end else if (b == CH_CR) begin
            cur_nxt = '0;
          end else if (b == CH_LF) begin
            cur_nxt   = '0;
            q_push    = 1'b1;
            q_cmd.act = ACT_NEWLINE;
            q_cmd.col = '0;
          end else if (b == CH_BS) begin
            if (cur_r != '0) cur_nxt = cur_r - CW'(1);
          end else if (b == CH_TAB) begin
            cur_nxt = CW'(tab_end);
            if (tab_cnt != '0) begin
              q_push         = 1'b1;
              q_cmd.chr      = CH_SPACE;
              q_cmd.cnt      = tab_cnt;
              q_cmd.step_col = 1'b1;
            end
          end else if ((b >= CH_SPACE && b < CH_DEL) || b >= CH_HIGH) begin
            q_push    = 1'b1;
            q_cmd.chr = b;
            if (cur_r < CW'(MAX_COLUMN)) cur_nxt = cur_r + CW'(1);
          end
        end
        MODE_ESC: begin
          if (b == CH_LBRACK) begin
            mode_nxt   = MODE_CSI;
            pidx_nxt   = '0;
            csicnt_nxt = '0;
            for (int i = 0; i < MAX_PARAMS; i++) params_nxt[i] = '0;
          end else if (b == CH_USCORE || b == CH_UP_P) begin
            mode_nxt        = MODE_GFX;
            q_push          = 1'b1;
            q_cmd.act       = ACT_PASS;
            q_cmd.chr       = b;
            q_cmd.cnt       = 4'd2;
            q_cmd.esc_first = 1'b1;
          end else if (b == CH_RBRACK) begin
            mode_nxt = MODE_OSC;
          end else begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_CSI: begin
          if (b >= CH_FIN_LO && b <= CH_FIN_HI) begin
            mode_nxt = MODE_NORMAL;
            if (b == CH_UP_K) begin
              if (p0 == 16'd0) begin
                q_push    = 1'b1;
                q_cmd.act = ACT_ERASE_END;
              end else if (p0 == 16'd1 && cur_r != '0) begin
                q_push    = 1'b1;
                q_cmd.act = ACT_ERASE_BEFORE;
              end else if (p0 == 16'd2) begin
                q_push    = 1'b1;
                q_cmd.act = ACT_ERASE_LINE;
              end
            end else if (b == CH_UP_J) begin
              if (p0 == 16'd2) begin
                cur_nxt   = '0;
                q_push    = 1'b1;
                q_cmd.act = ACT_CLEAR;
                q_cmd.col = '0;
              end
            end else if (b == CH_UP_H || b == CH_LO_F) begin
              if (pidx_r != '0) begin
                cur_nxt = clamp_col((p1 != '0) ? p1 - 16'd1 : 16'd0, eff_w);
              end else begin
                cur_nxt = '0;
              end
            end else if (b == CH_UP_C) begin
              cur_nxt = (fwd_w >= eff_w) ? CW'(eff_w - SW'(1)) : CW'(fwd_w);
            end else if (b == CH_UP_D) begin
              cur_nxt = (SW'(step) >= cur_w) ? '0 : CW'(cur_w - SW'(step));
            end else if (b == CH_UP_G) begin
              cur_nxt = clamp_col((p0 != '0) ? p0 - 16'd1 : 16'd0, eff_w);
            end
          end else if (csicnt_r < CBW'(CSI_BYTE_LIMIT)) begin
            csicnt_nxt = csicnt_r + CBW'(1);
            if (b >= CH_0 && b <= CH_9) begin
              if (pidx_r < PIW'(MAX_PARAMS)) params_nxt[pidx_r[PIX-1:0]] = dig_val;
            end else if (b == CH_SEMI) begin
              if (pidx_r < PIW'(MAX_PARAMS)) pidx_nxt = pidx_r + PIW'(1);
            end
          end
        end
        MODE_OSC: begin
          if (b == CH_BEL || (b == CH_BSLASH && prev_r == CH_ESC)) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_GFX: begin
          q_push    = 1'b1;
          q_cmd.act = ACT_PASS;
          q_cmd.chr = b;
          if (b == CH_BEL || (b == CH_BSLASH && prev_r == CH_ESC)) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      cur_r    <= '0;
      prev_r   <= '0;
      pidx_r   <= '0;
      csicnt_r <= '0;
      cols_r   <= COLS_RESET;
      for (int i = 0; i < MAX_PARAMS; i++) params_r[i] <= '0;
    end else begin
      mode_r   <= mode_nxt;
      cur_r    <= cur_nxt;
      pidx_r   <= pidx_nxt;
      csicnt_r <= csicnt_nxt;
      params_r <= params_nxt;
      if (accept) prev_r <= b;
      if (cfg_wr_en) cols_r <= cfg_screen_columns;
    end
  end

endmodule

@@ sv/aelp_back.sv @@
// ----------------------------------------------------------------------------
// aelp_back: item back end
// Expands the queue head into result items, one per cycle, into an output
// register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module aelp_back
  import aelp_pkg::*;
#(
  parameter int MAX_COLUMN = MAX_COLUMN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_action,
  output logic [9:0] out_column,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // stepped columns stop where the cursor stops, and never pass 1023
  localparam int COL_LIM = (MAX_COLUMN < 1023) ? MAX_COLUMN : 1023;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  action_r;
  logic [9:0]  column_r;
  logic [7:0]  byte_r;
  logic        last_r;

  logic        load;
  logic        is_last;
  logic [10:0] col_sum;
  logic [9:0]  col_item;
  logic [7:0]  byte_item;

  assign load      = !q_empty && (!out_valid_r || !out_stall);
  assign is_last   = ({1'b0, idx_r} == q_head.cnt - 4'd1);
  assign q_pop     = load && is_last;
  assign col_sum   = {1'b0, q_head.col} + 11'(idx_r);
  assign col_item  = !q_head.step_col ? q_head.col :
                     ((col_sum > 11'(COL_LIM)) ? 10'(COL_LIM) : col_sum[9:0]);
  assign byte_item = (q_head.esc_first && idx_r == '0) ? CH_ESC : q_head.chr;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? '0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action_r <= 3'(q_head.act);
      column_r <= col_item;
      byte_r   <= byte_item;
      last_r   <= is_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = action_r;
  assign out_column = column_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;

endmodule

@@ sv/ansi_escape_line_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ansi_escape_line_parser_unit: terminal escape sequence line parser
// Turns a raw terminal byte stream into line-store commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_byte_in) takes one byte per item.
//   Output channel (out_valid / out_stall / out_*) gives zero or more result
//   items per byte; out_last marks the final item caused by a byte.
//   cfg_wr_en / cfg_screen_columns set the screen width; write only when idle.
// Timing:
//   A byte accepted by the front is written into the command queue, and its
//   first result reaches the outputs through the back end's output register.
//   The front takes one byte per cycle while the queue is not full. The back
//   end's single output register sets throughput: one item per cycle while
//   out_stall is low; a tab gives up to 8 items, a graphics string start 2.
//   in_stall rises only when the command queue (QUEUE_DEPTH entries) is full,
//   i.e. after a receiver stall or a run of tabs or graphics starts backs it up.
// Reset (synchronous, rst_n low): parser to normal mode, cursor 0, parameters
//   cleared, width 80, queue and output register empty.
// A stalled output item holds its value until taken.
// ----------------------------------------------------------------------------
module ansi_escape_line_parser_unit
  import aelp_pkg::*;
#(
  parameter int MAX_PARAMS     = MAX_PARAMS_DEF,
  parameter int CSI_BYTE_LIMIT = CSI_BYTE_LIMIT_DEF,
  parameter int TAB_WIDTH      = TAB_WIDTH_DEF,
  parameter int MAX_COLUMN     = MAX_COLUMN_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  // screen width register
  input  logic       cfg_wr_en,
  input  logic [9:0] cfg_screen_columns,
  // result items
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_action,
  output logic [9:0] out_column,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // front -> queue
  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  // queue -> back
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  // Front: parse, track cursor/params, one command per byte at most
  aelp_front #(
    .MAX_PARAMS     (MAX_PARAMS),
    .CSI_BYTE_LIMIT (CSI_BYTE_LIMIT),
    .TAB_WIDTH      (TAB_WIDTH),
    .MAX_COLUMN     (MAX_COLUMN)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_in         (in_byte_in),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_screen_columns (cfg_screen_columns),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_cmd              (q_cmd)
  );

  // Command queue decouples byte intake from item delivery
  aelp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: expand commands into items behind the output register
  aelp_back #(
    .MAX_COLUMN (MAX_COLUMN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_action (out_action),
    .out_column (out_column),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
